// ===== sv/mbrb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrb_pkg
// Shared types, codes and the CRC-16 byte update of the Modbus read bridge.
// ----------------------------------------------------------------------------
package mbrb_pkg;

	// Input operation codes
	localparam logic [1:0] OP_REQUEST  = 2'd0;
	localparam logic [1:0] OP_RESPONSE = 2'd1;
	localparam logic [1:0] OP_TIMEOUT  = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_DATA   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_CRC     = 2'd1;
	localparam logic [1:0] ST_COUNT   = 2'd2;
	localparam logic [1:0] ST_TIMEOUT = 2'd3;

	// CRC and framing constants
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] CRC_POLY     = 16'hA001;
	localparam logic [6:0]  MAX_COUNT_RST = 7'd120;
	localparam logic [6:0]  COUNT_CAP    = 7'd125;
	localparam logic [7:0]  RESP_OVERHEAD = 8'd5;
	localparam logic [7:0]  DATA_OFFSET  = 8'd3;

	// Most results caused by one input item
	localparam int unsigned MAX_RESULTS = 4;

	typedef enum logic [1:0] {
		PH_IDLE = 2'b01,
		PH_WAIT = 2'b10
	} phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic [1:0] status;
	} result_t;

	// All results of one input item
	typedef struct packed {
		logic [2:0]                    count;
		result_t [MAX_RESULTS-1:0]     slot;
	} bundle_t;

	// Reflected CRC-16 update over one byte
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'd0, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== sv/mbrb_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrb_in_if
// Input item channel: request bytes, response bytes and timeout events.
// ----------------------------------------------------------------------------
interface mbrb_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] data_byte;
	logic       last_request_byte;

	modport source (output valid, output operation, output data_byte,
		output last_request_byte, input ready);
	modport sink (input valid, input operation, input data_byte,
		input last_request_byte, output ready);
endinterface

// ===== sv/mbrb_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrb_out_if
// Result channel: transmit bytes, response data bytes and status.
// ----------------------------------------------------------------------------
interface mbrb_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] result_kind;
	logic [7:0] byte_value;
	logic [1:0] status_code;
	logic       run_last;

	modport source (output valid, output result_kind, output byte_value,
		output status_code, output run_last, input ready);
	modport sink (input valid, input result_kind, input byte_value,
		input status_code, input run_last, output ready);
endinterface

// ===== sv/mbrb_result_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrb_result_queue
// Holds the results of one input item and hands them out one per transfer.
// ----------------------------------------------------------------------------
module mbrb_result_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  mbrb_pkg::bundle_t bundle,
	output logic              can_load,
	mbrb_out_if.source        result
);
	import mbrb_pkg::*;

	logic [2:0]                rem_q;
	logic [1:0]                rd_q;
	result_t [MAX_RESULTS-1:0] slot_q;
	result_t                   head;

	// Room for a new bundle once the last held result goes out
	assign can_load = (rem_q == 3'd0) || ((rem_q == 3'd1) && result.ready);

	// Remaining count and read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
			rd_q  <= 2'd0;
		end else if (load) begin
			rem_q <= bundle.count;
			rd_q  <= 2'd0;
		end else if (result.valid && result.ready) begin
			rem_q <= rem_q - 3'd1;
			rd_q  <= rd_q + 2'd1;
		end
	end

	// Result slots
	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= bundle.slot;
		end
	end

	assign head               = slot_q[rd_q];
	assign result.valid       = (rem_q != 3'd0);
	assign result.result_kind = head.kind;
	assign result.byte_value  = head.value;
	assign result.status_code = head.status;
	assign result.run_last    = (rem_q == 3'd1);

endmodule

// ===== sv/modbus_rtu_read_bridge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_read_bridge
// Frames a Modbus RTU read request with CRC-16, checks the response and
// forwards its data bytes, closing each exchange with a status result.
// ----------------------------------------------------------------------------
//  channel   dir  handshake             payload
//  item      in   valid/ready           operation, data_byte, last_request_byte
//  result    out  valid/ready           result_kind, byte_value, status_code,
//                                       run_last
//  config    in   wr_en (no wait)       wr_data = max_register_count
//
// An item is processed in the cycle of its transfer; its results (0 to 4) are
// registered and leave one per cycle while result.ready is high, the first on
// the next cycle. A new item is taken as the last held result transfers, so
// single-result items run at one per cycle while no result stalls.
// Reset returns to idle with max_register_count = 120.
// A stalled result holds the item channel until it transfers.
// ----------------------------------------------------------------------------
module modbus_rtu_read_bridge #(
	parameter int unsigned MAX_REQUEST_BYTES = 254
) (
	input  logic       clk,
	input  logic       arst_n,
	mbrb_in_if.sink    item,
	mbrb_out_if.source result,
	input  logic       wr_en,
	input  logic [6:0] wr_data
);
	import mbrb_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_REQUEST_BYTES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_REQUEST_BYTES - 1);

	phase_t           phase_q,    phase_d;
	logic [IDX_W-1:0] req_idx_q,  req_idx_d;
	logic [15:0]      req_crc_q,  req_crc_d;
	logic [15:0]      reg_cnt_q,  reg_cnt_d;
	logic [7:0]       rsp_idx_q,  rsp_idx_d;
	logic [7:0]       rsp_len_q,  rsp_len_d;
	logic [15:0]      rsp_crc_q,  rsp_crc_d;
	logic [7:0]       rx_low_q,   rx_low_d;
	logic [6:0]       max_cnt_q;

	logic        accept;
	logic        can_load;
	logic [6:0]  limit;
	logic [15:0] req_crc_new;
	logic        last_eff;
	logic        bad_count;
	logic [8:0]  rsp_pos;
	bundle_t     bundle;

	assign accept     = item.valid && item.ready;
	assign item.ready = can_load;

	// Register limit, capped
	assign limit = (max_cnt_q > COUNT_CAP) ? COUNT_CAP : max_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_cnt_q <= MAX_COUNT_RST;
		end else if (wr_en) begin
			max_cnt_q <= wr_data;
		end
	end

	assign req_crc_new = crc_feed(req_crc_q, item.data_byte);
	assign rsp_pos     = {1'b0, rsp_idx_q} + 9'd2;

	// Next state and results of the item in transfer
	always_comb begin
		phase_d   = phase_q;
		req_idx_d = req_idx_q;
		req_crc_d = req_crc_q;
		reg_cnt_d = reg_cnt_q;
		rsp_idx_d = rsp_idx_q;
		rsp_len_d = rsp_len_q;
		rsp_crc_d = rsp_crc_q;
		rx_low_d  = rx_low_q;
		bundle    = '0;
		last_eff  = 1'b0;
		bad_count = 1'b0;

		case (item.operation)
			OP_REQUEST: begin
				if (phase_q == PH_IDLE) begin
					bundle.slot[0] = '{kind: KIND_TX, value: item.data_byte, status: ST_OK};
					bundle.count   = 3'd1;
					req_crc_d      = req_crc_new;
					if (req_idx_q == IDX_W'(4)) begin
						reg_cnt_d = {item.data_byte, reg_cnt_q[7:0]};
					end else if (req_idx_q == IDX_W'(5)) begin
						reg_cnt_d = {reg_cnt_q[15:8], item.data_byte};
					end
					last_eff = item.last_request_byte || (req_idx_q == LAST_IDX);
					if (!last_eff) begin
						req_idx_d = req_idx_q + IDX_W'(1);
					end else begin
						bundle.slot[1] = '{kind: KIND_TX, value: req_crc_new[7:0],
							status: ST_OK};
						bundle.slot[2] = '{kind: KIND_TX, value: req_crc_new[15:8],
							status: ST_OK};
						bundle.count   = 3'd3;
						bad_count = (req_idx_q < IDX_W'(5)) || (reg_cnt_d == 16'd0) ||
							(reg_cnt_d > {9'd0, limit});
						if (bad_count) begin
							bundle.slot[3] = '{kind: KIND_STATUS, value: 8'd0,
								status: ST_COUNT};
							bundle.count   = 3'd4;
							phase_d   = PH_IDLE;
							req_idx_d = '0;
							req_crc_d = CRC_INIT;
							reg_cnt_d = 16'd0;
							rsp_idx_d = 8'd0;
							rsp_len_d = 8'd0;
							rsp_crc_d = CRC_INIT;
							rx_low_d  = 8'd0;
						end else begin
							phase_d   = PH_WAIT;
							rsp_idx_d = 8'd0;
							rsp_crc_d = CRC_INIT;
							rx_low_d  = 8'd0;
							rsp_len_d = {reg_cnt_d[6:0], 1'b0} + RESP_OVERHEAD;
						end
					end
				end
			end
			OP_RESPONSE: begin
				if (phase_q == PH_WAIT) begin
					if (rsp_pos < {1'b0, rsp_len_q}) begin
						// Header or data byte
						rsp_crc_d = crc_feed(rsp_crc_q, item.data_byte);
						if (rsp_idx_q >= DATA_OFFSET) begin
							bundle.slot[0] = '{kind: KIND_DATA, value: item.data_byte,
								status: ST_OK};
							bundle.count   = 3'd1;
						end
						rsp_idx_d = rsp_idx_q + 8'd1;
					end else if (rsp_pos == {1'b0, rsp_len_q}) begin
						// CRC low byte
						rx_low_d  = item.data_byte;
						rsp_idx_d = rsp_idx_q + 8'd1;
					end else begin
						// CRC high byte closes the exchange
						bundle.slot[0] = '{kind: KIND_STATUS, value: 8'd0,
							status: ({item.data_byte, rx_low_q} == rsp_crc_q) ? ST_OK : ST_CRC};
						bundle.count   = 3'd1;
						phase_d   = PH_IDLE;
						req_idx_d = '0;
						req_crc_d = CRC_INIT;
						reg_cnt_d = 16'd0;
						rsp_idx_d = 8'd0;
						rsp_len_d = 8'd0;
						rsp_crc_d = CRC_INIT;
						rx_low_d  = 8'd0;
					end
				end
			end
			OP_TIMEOUT: begin
				if (phase_q == PH_WAIT) begin
					bundle.slot[0] = '{kind: KIND_STATUS, value: 8'd0, status: ST_TIMEOUT};
					bundle.count   = 3'd1;
					phase_d   = PH_IDLE;
					req_idx_d = '0;
					req_crc_d = CRC_INIT;
					reg_cnt_d = 16'd0;
					rsp_idx_d = 8'd0;
					rsp_len_d = 8'd0;
					rsp_crc_d = CRC_INIT;
					rx_low_d  = 8'd0;
				end
			end
			default: begin
				// unused operation code: no effect
			end
		endcase
	end

	// Exchange state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			req_idx_q <= '0;
			req_crc_q <= CRC_INIT;
			reg_cnt_q <= 16'd0;
			rsp_idx_q <= 8'd0;
			rsp_len_q <= 8'd0;
			rsp_crc_q <= CRC_INIT;
			rx_low_q  <= 8'd0;
		end else if (accept) begin
			phase_q   <= phase_d;
			req_idx_q <= req_idx_d;
			req_crc_q <= req_crc_d;
			reg_cnt_q <= reg_cnt_d;
			rsp_idx_q <= rsp_idx_d;
			rsp_len_q <= rsp_len_d;
			rsp_crc_q <= rsp_crc_d;
			rx_low_q  <= rx_low_d;
		end
	end

	mbrb_result_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.bundle   (bundle),
		.can_load (can_load),
		.result   (result)
	);

endmodule

// ===== sim/modbus_rtu_read_bridge_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_read_bridge_test
// Self-checking bench for the Modbus RTU read bridge. Request frames and
// responses are fed through the item channel with random gaps. A bit-level
// model of the framing and the CRC-16 predicts every result. Results are
// taken with random stalls and checked in order, field by field. The register
// count limit is changed between traffic phases.
// ----------------------------------------------------------------------------
module modbus_rtu_read_bridge_test;
	import mbrb_pkg::*;

	localparam int unsigned REQ_MAX      = 254;
	localparam int unsigned MIN_REQUEST  = 6;    // address .. count low
	localparam logic [1:0]  OP_UNUSED    = 2'd3;
	localparam logic [1:0]  NO_STATUS    = 2'd0; // status field outside status results
	localparam int          WHOLE        = 1 << 10;
	localparam int          NO_FLIP      = -1;
	localparam int unsigned RANDOM_ITEMS = 170;
	localparam int unsigned SETTLE       = 8;
	localparam int unsigned HOLD_AFTER   = 60;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned STALL_LIMIT  = 2000;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] value;
		logic       mark;
	} feed_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic [1:0] status;
		logic       last;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [6:0] wr_data;
	logic calm = 1'b0;

	mbrb_in_if  item_ch ();
	mbrb_out_if result_ch ();

	modbus_rtu_read_bridge #(
		.MAX_REQUEST_BYTES(REQ_MAX)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.wr_en(wr_en),
		.wr_data(wr_data)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	feed_item_t  feed_q[$];
	outcome_t    owed_q[$];
	logic [7:0]  frame_buf[$];
	int unsigned fed_items = 0;
	int unsigned errors = 0;
	int unsigned quiet_cycles = 0;

	// bridge model state
	logic [6:0]  max_cfg;
	phase_t      ph;
	logic [7:0]  req_idx;
	logic [15:0] req_crc;
	logic [15:0] reg_count;
	logic [7:0]  rsp_idx;
	logic [7:0]  rsp_len;
	logic [15:0] rsp_crc;
	logic [7:0]  crc_lo;

	// Modbus CRC-16, one input bit at a time, LSB first
	function automatic logic [15:0] crc16_serial(input logic [15:0] acc, input logic [7:0] d);
		logic [15:0] c;
		c = acc;
		for (int k = 0; k < 8; k++) begin
			c = (c[0] ^ d[k]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic outcome_t mk(input logic [1:0] k, input logic [7:0] v, input logic [1:0] s);
		outcome_t o;
		o.kind   = k;
		o.value  = v;
		o.status = s;
		o.last   = 1'b0;
		return o;
	endfunction

	// mostly short gaps, some long ones, none in a calm phase
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [7:0] pick_byte();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) return 8'h00;
		if (r == 1) return 8'hFF;
		return 8'($urandom);
	endfunction

	task automatic report(input string what);
		errors++;
		if (errors <= 40) $display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic clear_exchange();
		ph        = PH_IDLE;
		req_idx   = '0;
		req_crc   = CRC_INIT;
		reg_count = '0;
		rsp_idx   = '0;
		rsp_len   = '0;
		rsp_crc   = CRC_INIT;
		crc_lo    = '0;
	endtask

	// Results caused by one accepted item, appended to owed_q
	task automatic bridge_step(input logic [1:0] op, input logic [7:0] b, input logic mark);
		outcome_t    batch[$];
		int unsigned idx;
		int unsigned cap;
		logic        closing;
		logic [15:0] got_crc;
		if (op == OP_REQUEST && ph == PH_IDLE) begin
			idx = req_idx;
			batch.push_back(mk(KIND_TX, b, NO_STATUS));
			req_crc = crc16_serial(req_crc, b);
			if (idx == 4) reg_count[15:8] = b;
			else if (idx == 5) reg_count[7:0] = b;
			// an over-long request is closed at the last slot
			closing = mark || (idx + 1 >= REQ_MAX);
			if (!closing) begin
				req_idx = 8'(idx + 1);
			end else begin
				batch.push_back(mk(KIND_TX, req_crc[7:0], NO_STATUS));
				batch.push_back(mk(KIND_TX, req_crc[15:8], NO_STATUS));
				cap = (max_cfg > COUNT_CAP) ? COUNT_CAP : max_cfg;
				if (idx + 1 < MIN_REQUEST || reg_count == 0 || reg_count > cap) begin
					batch.push_back(mk(KIND_STATUS, 8'h00, ST_COUNT));
					clear_exchange();
				end else begin
					ph      = PH_WAIT;
					rsp_idx = '0;
					rsp_crc = CRC_INIT;
					crc_lo  = '0;
					rsp_len = 8'(RESP_OVERHEAD + 2 * reg_count);
				end
			end
		end else if (op == OP_RESPONSE && ph == PH_WAIT) begin
			idx = rsp_idx;
			if (idx + 2 < rsp_len) begin
				rsp_crc = crc16_serial(rsp_crc, b);
				if (idx >= DATA_OFFSET) batch.push_back(mk(KIND_DATA, b, NO_STATUS));
				rsp_idx = 8'(idx + 1);
			end else if (idx + 2 == rsp_len) begin
				crc_lo  = b;
				rsp_idx = 8'(idx + 1);
			end else begin
				got_crc = {b, crc_lo};
				batch.push_back(mk(KIND_STATUS, 8'h00, (got_crc == rsp_crc) ? ST_OK : ST_CRC));
				clear_exchange();
			end
		end else if (op == OP_TIMEOUT && ph == PH_WAIT) begin
			batch.push_back(mk(KIND_STATUS, 8'h00, ST_TIMEOUT));
			clear_exchange();
		end
		if (batch.size() != 0) batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i]) owed_q.push_back(batch[i]);
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_item(input logic [1:0] op, input logic [7:0] b, input logic mark,
			input logic counted);
		feed_item_t s;
		s.op    = op;
		s.value = b;
		s.mark  = mark;
		feed_q.push_back(s);
		if (counted) fed_items++;
	endtask

	// read request with the register count at bytes 4 and 5
	task automatic send_request(input int unsigned n_bytes, input logic [15:0] count,
			input logic mark_end);
		logic [7:0] b;
		for (int i = 0; i < n_bytes; i++) begin
			case (i)
				1: b = ($urandom_range(0, 7) != 0) ? 8'h03 : pick_byte();
				4: b = count[15:8];
				5: b = count[7:0];
				default: b = pick_byte();
			endcase
			push_item(OP_REQUEST, b, mark_end && (i == n_bytes - 1), 1'b1);
		end
	endtask

	// response frame for count registers; cut short by a timeout after cut bytes,
	// one bit flipped at flip_at, ignored items mixed in when noisy
	task automatic send_response(input logic [15:0] count, input logic noisy, input int cut,
			input int flip_at);
		logic [15:0] crc;
		frame_buf.delete();
		frame_buf.push_back(pick_byte());
		frame_buf.push_back(8'h03);
		frame_buf.push_back(8'(2 * count));
		for (int i = 0; i < 2 * count; i++) frame_buf.push_back(pick_byte());
		crc = CRC_INIT;
		foreach (frame_buf[i]) crc = crc16_serial(crc, frame_buf[i]);
		frame_buf.push_back(crc[7:0]);
		frame_buf.push_back(crc[15:8]);
		if (flip_at >= 0) frame_buf[flip_at] = frame_buf[flip_at] ^ (8'h01 << $urandom_range(0, 7));
		for (int i = 0; i < frame_buf.size() && i < cut; i++) begin
			if (noisy && $urandom_range(0, 3) == 0) begin
				push_item(($urandom_range(0, 1) != 0) ? OP_REQUEST : OP_UNUSED, pick_byte(),
					1'($urandom_range(0, 1)), 1'b0);
			end
			push_item(OP_RESPONSE, frame_buf[i], 1'($urandom_range(0, 1)), 1'b1);
		end
		if (cut < frame_buf.size()) push_item(OP_TIMEOUT, pick_byte(), 1'($urandom_range(0, 1)), 1'b1);
	endtask

	task automatic random_exchange();
		int unsigned cap;
		int unsigned sel;
		int unsigned n_req;
		int unsigned rlen;
		logic [15:0] cnt;
		cap = (max_cfg > COUNT_CAP) ? COUNT_CAP : max_cfg;
		// stray response, timeout or unused op while idle
		if ($urandom_range(0, 7) == 0) begin
			push_item(2'($urandom_range(1, 3)), pick_byte(), 1'($urandom_range(0, 1)), 1'b0);
		end
		sel = $urandom_range(0, 99);
		if (sel < 65) cnt = 16'($urandom_range(1, (cap < 4) ? cap : 4));
		else if (sel < 75) cnt = 16'($urandom_range(1, (cap < 12) ? cap : 12));
		else if (sel < 80) cnt = 16'(cap);
		else if (sel < 88) cnt = 16'(cap + 1);
		else if (sel < 93) cnt = 16'd0;
		else cnt = 16'($urandom);
		if ($urandom_range(0, 9) == 0) n_req = $urandom_range(1, MIN_REQUEST - 1);
		else if ($urandom_range(0, 3) == 0) n_req = MIN_REQUEST + $urandom_range(1, 4);
		else n_req = MIN_REQUEST;
		send_request(n_req, cnt, 1'b1);
		if (n_req >= MIN_REQUEST && cnt != 0 && cnt <= cap) begin
			rlen = RESP_OVERHEAD + 2 * cnt;
			sel = $urandom_range(0, 99);
			if (sel < 60) send_response(cnt, 1'b0, WHOLE, NO_FLIP);
			else if (sel < 72) send_response(cnt, 1'b0, WHOLE, $urandom_range(0, rlen - 1));
			else if (sel < 85) send_response(cnt, 1'b0, $urandom_range(0, rlen - 1), NO_FLIP);
			else send_response(cnt, 1'b1, WHOLE, NO_FLIP);
		end else if ($urandom_range(0, 3) == 0) begin
			push_item(2'($urandom_range(1, 3)), pick_byte(), 1'($urandom_range(0, 1)), 1'b0);
		end
	endtask

	// wait until every item is sent and every result has come, then let the block settle
	task automatic drain();
		do @(negedge clk);
		while (feed_q.size() != 0 || item_ch.valid || owed_q.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_limit(input logic [6:0] v);
		@(posedge clk);
		wr_en   <= 1'b1;
		wr_data <= v;
		@(posedge clk);
		wr_en   <= 1'b0;
		max_cfg = v;
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Item driver: one transfer per handshake, random gaps between items
	// ------------------------------------------------------------------
	int unsigned feed_gap;
	feed_item_t  next_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid             <= 1'b0;
			item_ch.operation         <= OP_REQUEST;
			item_ch.data_byte         <= 8'h00;
			item_ch.last_request_byte <= 1'b0;
			feed_gap                  <= 0;
			clear_exchange();
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				bridge_step(item_ch.operation, item_ch.data_byte, item_ch.last_request_byte);
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (feed_gap != 0) begin
					feed_gap      <= feed_gap - 1;
					item_ch.valid <= 1'b0;
				end else if (feed_q.size() != 0) begin
					next_item = feed_q.pop_front();
					item_ch.valid             <= 1'b1;
					item_ch.operation         <= next_item.op;
					item_ch.data_byte         <= next_item.value;
					item_ch.last_request_byte <= next_item.mark;
					feed_gap                  <= pick_gap();
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: random stalls, one long hold-off, in-order check
	// ------------------------------------------------------------------
	int unsigned sink_gap;
	int unsigned hold_left;
	logic        hold_done;
	int unsigned results_seen;
	outcome_t    want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			sink_gap        <= 0;
			hold_left       <= 0;
			hold_done       <= 1'b0;
			results_seen    <= 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				results_seen <= results_seen + 1;
				if (owed_q.size() == 0) begin
					report($sformatf("result %0d with nothing owed: kind %0d byte %02h status %0d",
						results_seen, result_ch.result_kind, result_ch.byte_value,
						result_ch.status_code));
				end else begin
					want = owed_q.pop_front();
					if (result_ch.result_kind !== want.kind)
						report($sformatf("result %0d kind %0d, want %0d", results_seen,
							result_ch.result_kind, want.kind));
					if (result_ch.byte_value !== want.value)
						report($sformatf("result %0d byte %02h, want %02h", results_seen,
							result_ch.byte_value, want.value));
					if (result_ch.status_code !== want.status)
						report($sformatf("result %0d status %0d, want %0d", results_seen,
							result_ch.status_code, want.status));
					if (result_ch.run_last !== want.last)
						report($sformatf("result %0d run_last %0b, want %0b", results_seen,
							result_ch.run_last, want.last));
				end
			end
			if (hold_left != 0) begin
				hold_left       <= hold_left - 1;
				result_ch.ready <= 1'b0;
			end else if (!hold_done && results_seen >= HOLD_AFTER) begin
				// long back-pressure so the block fills and stalls its input
				hold_done       <= 1'b1;
				hold_left       <= HOLD_CYCLES;
				result_ch.ready <= 1'b0;
			end else if (sink_gap != 0) begin
				sink_gap        <= sink_gap - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				sink_gap        <= pick_gap();
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog on cycles without any transfer
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		while (quiet_cycles < STALL_LIMIT) @(posedge clk);
		$display("RESULT: ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		int unsigned rand_base;
		int unsigned phase_end;
		int unsigned sel;
		arst_n  = 1'b1;
		wr_en   = 1'b0;
		wr_data = '0;
		max_cfg = MAX_COUNT_RST;
		// assert reset once every process waits on its falling edge
		#0.5;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset limit: one-byte request, ignored ops while idle, short request,
		// valid read with ignored items while waiting
		push_item(OP_REQUEST, 8'hFF, 1'b1, 1'b1);
		push_item(OP_RESPONSE, 8'h00, 1'b0, 1'b0);
		push_item(OP_TIMEOUT, 8'h5A, 1'b1, 1'b0);
		push_item(OP_UNUSED, 8'hA5, 1'b0, 1'b0);
		send_request(MIN_REQUEST - 1, 16'd1, 1'b1);
		send_request(MIN_REQUEST, 16'd1, 1'b1);
		push_item(OP_REQUEST, 8'h3C, 1'b1, 1'b0);
		push_item(OP_UNUSED, 8'hC3, 1'b1, 1'b0);
		send_response(16'd1, 1'b0, WHOLE, NO_FLIP);
		drain();

		// limit at the cap: largest count taken, one above refused
		write_limit(COUNT_CAP);
		send_request(MIN_REQUEST, 16'd125, 1'b1);
		send_response(16'd125, 1'b0, 5, NO_FLIP);
		send_request(MIN_REQUEST, 16'd126, 1'b1);
		drain();

		// register above the cap acts as the cap; over-long request closes itself
		write_limit(7'h7F);
		send_request(MIN_REQUEST, 16'd126, 1'b1);
		send_request(MIN_REQUEST, 16'd125, 1'b1);
		send_response(16'd125, 1'b0, 0, NO_FLIP);
		send_request(REQ_MAX, 16'd2, 1'b0);
		send_response(16'd2, 1'b0, WHOLE, NO_FLIP);
		drain();

		// zero limit refuses everything
		write_limit(7'h00);
		send_request(MIN_REQUEST, 16'd1, 1'b1);
		send_request(MIN_REQUEST + 1, 16'd0, 1'b1);
		drain();

		// limit of one: CRC error, noisy response, refusal
		write_limit(7'd1);
		send_request(MIN_REQUEST, 16'd1, 1'b1);
		send_response(16'd1, 1'b0, WHOLE, 4);
		send_request(MIN_REQUEST + 2, 16'd1, 1'b1);
		send_response(16'd1, 1'b1, WHOLE, NO_FLIP);
		send_request(MIN_REQUEST, 16'd2, 1'b1);
		drain();

		// random phases, each with its own limit
		rand_base = fed_items;
		while (fed_items - rand_base < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 9);
			if (sel < 4) write_limit(MAX_COUNT_RST);
			else if (sel < 7) write_limit(7'($urandom_range(1, 6)));
			else write_limit(7'($urandom_range(1, 127)));
			calm <= ($urandom_range(0, 3) == 0);
			phase_end = fed_items + $urandom_range(25, 50);
			while (fed_items < phase_end) random_exchange();
			drain();
		end

		repeat (20) @(negedge clk);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
